>>> rtl/phbb_pkg.sv
// Shared types, constants and the arctangent table for the pursuit heading controller.
// Used by every module of the block; depends on nothing else.
package phbb_pkg;

   // Default structural sizes.
   localparam int POS_WIDTH_DEF     = 24;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // The arctangent table has this many entries; more stages are not built.
   localparam int ATAN_TABLE_LEN = 24;

   // Configuration port sizes.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register reset values: a quarter-of-a-quarter turn deadband, 1.1 rad/s
   // times 4096, and the two commanded speeds.
   localparam logic [14:0] DEADBAND_RESET      = 15'd4096;
   localparam logic [14:0] MAX_TURN_RATE_RESET = 15'd4506;
   localparam logic [15:0] TURNING_SPEED_RESET = 16'd50;
   localparam logic [15:0] CRUISE_SPEED_RESET  = 16'd1000;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEADBAND_ANGLE = 8'd0,
      CSR_MAX_TURN_RATE  = 8'd1,
      CSR_TURNING_SPEED  = 8'd2,
      CSR_CRUISE_SPEED   = 8'd3
   } csr_index_type;

   // arctan(2^-i) in units of 2^32 per turn, rounded to nearest.
   localparam logic [31:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // One input transaction.
   typedef struct packed {
      logic signed [23:0] own_x;
      logic signed [23:0] own_y;
      logic [15:0]        own_heading;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [15:0] turn_rate;
      logic [15:0]        speed;
      logic [15:0]        bearing;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [14:0] deadband_angle;
      logic [14:0] max_turn_rate;
      logic [15:0] turning_speed;
      logic [15:0] cruise_speed;
   } cfg_type;

   // Control that travels with each item down the pipeline.
   typedef struct packed {
      logic valid;
      logic zero;    // target and vehicle coincide
   } ctl_type;

endpackage

>>> rtl/phbb_pre.sv
// Input stage: position differences, half-plane fold and CORDIC seed.
// Depends on phbb_pkg.
module phbb_pre #(
   parameter int POS_WIDTH   = 24,
   parameter int ANGLE_WIDTH = 16,
   parameter int XW          = POS_WIDTH + 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    req_valid,
   input  phbb_pkg::req_type       req_payload,
   output phbb_pkg::ctl_type       ctl_o,
   output logic signed [XW-1:0]    x_o,
   output logic signed [XW-1:0]    y_o,
   output logic [31:0]             z_o,
   output logic [ANGLE_WIDTH-1:0]  heading_o
);
   import phbb_pkg::*;

   logic [POS_WIDTH-1:0]   ox, oy, tx, ty;
   logic signed [XW-1:0]   dx, dy, sx, sy;
   logic                   flip;

   ctl_type                ctl_ff, ctl_in;
   logic signed [XW-1:0]   x_ff, x_in, y_ff, y_in;
   logic [31:0]            z_ff, z_in;
   logic [ANGLE_WIDTH-1:0] heading_ff, heading_in;

   // Take the low POS_WIDTH bits of each coordinate as a signed value.
   always_comb begin
      ox = POS_WIDTH'($unsigned(req_payload.own_x));
      oy = POS_WIDTH'($unsigned(req_payload.own_y));
      tx = POS_WIDTH'($unsigned(req_payload.target_x));
      ty = POS_WIDTH'($unsigned(req_payload.target_y));
      dx = XW'($signed(tx)) - XW'($signed(ox));
      dy = XW'($signed(ty)) - XW'($signed(oy));
      sx = dx <<< 16;
      sy = dy <<< 16;
      flip = dx[XW-1];
   end

   // Fold the left half-plane onto the right one, starting half a turn away.
   always_comb begin
      ctl_in.valid = req_valid;
      ctl_in.zero  = (dx == '0) && (dy == '0);
      x_in         = flip ? -sx : sx;
      y_in         = flip ? -sy : sy;
      z_in         = flip ? 32'h8000_0000 : 32'h0000_0000;
      heading_in   = ANGLE_WIDTH'(req_payload.own_heading);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         heading_ff <= heading_in;
      end
   end

   assign ctl_o     = ctl_ff;
   assign x_o       = x_ff;
   assign y_o       = y_ff;
   assign z_o       = z_ff;
   assign heading_o = heading_ff;

endmodule

>>> rtl/phbb_cordic_stage.sv
// One vectoring CORDIC iteration with its own pipeline register.
// Depends on phbb_pkg for the arctangent table and the control struct.
module phbb_cordic_stage #(
   parameter int XW          = 43,
   parameter int ANGLE_WIDTH = 16,
   parameter int STAGE       = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  phbb_pkg::ctl_type       ctl_i,
   input  logic signed [XW-1:0]    x_i,
   input  logic signed [XW-1:0]    y_i,
   input  logic [31:0]             z_i,
   input  logic [ANGLE_WIDTH-1:0]  heading_i,
   output phbb_pkg::ctl_type       ctl_o,
   output logic signed [XW-1:0]    x_o,
   output logic signed [XW-1:0]    y_o,
   output logic [31:0]             z_o,
   output logic [ANGLE_WIDTH-1:0]  heading_o
);
   import phbb_pkg::*;

   logic signed [XW-1:0]   xs, ys;
   ctl_type                ctl_ff;
   logic signed [XW-1:0]   x_ff, x_in, y_ff, y_in;
   logic [31:0]            z_ff, z_in;
   logic [ANGLE_WIDTH-1:0] heading_ff;

   // Rotate toward the x axis; the sign of y picks the direction.
   always_comb begin
      xs = x_i >>> STAGE;
      ys = y_i >>> STAGE;
      if (y_i[XW-1]) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN_TABLE[STAGE];
      end else begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         heading_ff <= heading_i;
      end
   end

   assign ctl_o     = ctl_ff;
   assign x_o       = x_ff;
   assign y_o       = y_ff;
   assign z_o       = z_ff;
   assign heading_o = heading_ff;

endmodule

>>> rtl/phbb_post.sv
// Bearing rounding and wrapped heading error, one pipeline stage.
// Depends on phbb_pkg for the control struct.
module phbb_post #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  phbb_pkg::ctl_type       ctl_i,
   input  logic [31:0]             z_i,
   input  logic [ANGLE_WIDTH-1:0]  heading_i,
   output logic                    valid_o,
   output logic [ANGLE_WIDTH-1:0]  bearing_o,
   output logic [ANGLE_WIDTH-1:0]  diff_o
);
   import phbb_pkg::*;

   localparam logic [31:0] ROUND_ADD = 32'd1 << (31 - ANGLE_WIDTH);

   logic [31:0]            rounded;
   logic                   valid_ff;
   logic [ANGLE_WIDTH-1:0] bearing_ff, bearing_in, diff_ff, diff_in;

   // Round half-up to the angle width; coincident points give bearing zero.
   always_comb begin
      rounded    = z_i + ROUND_ADD;
      bearing_in = ctl_i.zero ? '0 : rounded[31 -: ANGLE_WIDTH];
      diff_in    = bearing_in - heading_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bearing_ff <= bearing_in;
         diff_ff    <= diff_in;
      end
   end

   assign valid_o   = valid_ff;
   assign bearing_o = bearing_ff;
   assign diff_o    = diff_ff;

endmodule

>>> rtl/phbb_out.sv
// Turn decision and the output register with a one-entry skid buffer.
// Depends on phbb_pkg for the result and configuration structs.
module phbb_out #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  phbb_pkg::cfg_type       cfg,
   input  logic                    post_valid,
   input  logic [ANGLE_WIDTH-1:0]  post_bearing,
   input  logic [ANGLE_WIDTH-1:0]  post_diff,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output phbb_pkg::rsp_type       rsp_payload,
   output logic                    skid_valid
);
   import phbb_pkg::*;

   logic                   neg, in_band, rsp_load;
   logic [ANGLE_WIDTH-1:0] mag;
   logic [15:0]            rate;
   rsp_type                res;

   logic                   rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_type                rsp_ff, rsp_in, skid_ff, skid_in;

   // Error magnitude against the deadband; half a turn counts as negative.
   always_comb begin
      neg           = post_diff[ANGLE_WIDTH-1];
      mag           = neg ? (ANGLE_WIDTH'(0) - post_diff) : post_diff;
      in_band       = 32'(mag) < 32'(cfg.deadband_angle);
      rate          = 16'(cfg.max_turn_rate);
      res.turn_rate = in_band ? 16'sd0 : $signed(neg ? (16'd0 - rate) : rate);
      res.speed     = in_band ? cfg.cruise_speed : cfg.turning_speed;
      res.bearing   = 16'(post_bearing);
   end

   // The output register takes the skid entry first, else the pipeline result.
   always_comb begin
      rsp_load      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_load) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = post_valid;
            rsp_in        = res;
         end
      end else if (post_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign skid_valid  = skid_valid_ff;

endmodule

>>> rtl/pursuit_heading_bang_bang.sv
// Top level of the bang-bang pursuit heading controller with deadband.
// Depends on phbb_pkg, phbb_pre, phbb_cordic_stage, phbb_post and phbb_out.
//
// The block takes one pose transaction (own position, heading, target position) per cycle
// while req_stall is low and returns one result per transaction, in order: the bearing to
// the target as a binary angle, a turn rate of zero or plus/minus max_turn_rate, and the
// cruise or turning speed. The stages are one input stage, one register per CORDIC
// iteration, one rounding and error stage, and the output register. Throughput is one
// transaction per cycle while req_stall is low, set by giving every CORDIC iteration its
// own stage. The output register is backed by a one-entry skid buffer, and req_stall is
// high exactly while that buffer is occupied; the whole pipeline then holds.
// Configuration registers are written through the csr_ port, which is always ready, and
// should change only while no transaction is in flight.
module pursuit_heading_bang_bang #(
   parameter int POS_WIDTH     = phbb_pkg::POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = phbb_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = phbb_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  phbb_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output phbb_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [phbb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [phbb_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import phbb_pkg::*;

   localparam int XW = POS_WIDTH + 19;
   localparam int NUM_STAGES =
      (CORDIC_STAGES > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STAGES;

   cfg_type                cfg_ff, cfg_in;
   logic                   en, skid_valid;

   ctl_type                ctl_s     [NUM_STAGES+1];
   logic signed [XW-1:0]   x_s       [NUM_STAGES+1];
   logic signed [XW-1:0]   y_s       [NUM_STAGES+1];
   logic [31:0]            z_s       [NUM_STAGES+1];
   logic [ANGLE_WIDTH-1:0] heading_s [NUM_STAGES+1];

   logic                   post_valid;
   logic [ANGLE_WIDTH-1:0] post_bearing, post_diff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEADBAND_ANGLE: cfg_in.deadband_angle = csr_data[14:0];
            CSR_MAX_TURN_RATE:  cfg_in.max_turn_rate  = csr_data[14:0];
            CSR_TURNING_SPEED:  cfg_in.turning_speed  = csr_data;
            CSR_CRUISE_SPEED:   cfg_in.cruise_speed   = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_angle <= DEADBAND_RESET;
         cfg_ff.max_turn_rate  <= MAX_TURN_RATE_RESET;
         cfg_ff.turning_speed  <= TURNING_SPEED_RESET;
         cfg_ff.cruise_speed   <= CRUISE_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The pipeline advances whenever the skid buffer is free.
   assign en        = !skid_valid;
   assign req_stall = skid_valid;

   phbb_pre #(
      .POS_WIDTH   (POS_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .XW          (XW)
   ) u_pre (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .ctl_o       (ctl_s[0]),
      .x_o         (x_s[0]),
      .y_o         (y_s[0]),
      .z_o         (z_s[0]),
      .heading_o   (heading_s[0])
   );

   // One registered CORDIC iteration per stage.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cordic
      phbb_cordic_stage #(
         .XW          (XW),
         .ANGLE_WIDTH (ANGLE_WIDTH),
         .STAGE       (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl_i     (ctl_s[i]),
         .x_i       (x_s[i]),
         .y_i       (y_s[i]),
         .z_i       (z_s[i]),
         .heading_i (heading_s[i]),
         .ctl_o     (ctl_s[i+1]),
         .x_o       (x_s[i+1]),
         .y_o       (y_s[i+1]),
         .z_o       (z_s[i+1]),
         .heading_o (heading_s[i+1])
      );
   end

   phbb_post #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_i     (ctl_s[NUM_STAGES]),
      .z_i       (z_s[NUM_STAGES]),
      .heading_i (heading_s[NUM_STAGES]),
      .valid_o   (post_valid),
      .bearing_o (post_bearing),
      .diff_o    (post_diff)
   );

   phbb_out #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .post_valid   (post_valid),
      .post_bearing (post_bearing),
      .post_diff    (post_diff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .skid_valid   (skid_valid)
   );

   // The skid entry is only ever occupied behind a held result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid |-> rsp_valid)
      else $error("skid buffer occupied while output register is empty");

   // The skid buffer fills only when the output was stalled.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid) |-> $past(rsp_valid && rsp_stall))
      else $error("skid buffer filled while output was not stalled");

   // Reset empties the output side.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !skid_valid)
      else $error("output not empty after reset");

endmodule
